@@ rtl/ckv_pkg.sv @@
// ----------------------------------------------------------------------------
// ckv_pkg
// shared types and constants of the checkpoint container validator
// ----------------------------------------------------------------------------
package ckv_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int QUEUE_AW     = 2;
  localparam int QUEUE_DEPTH  = 1 << QUEUE_AW;
  localparam int OUT_BITS     = 264;

  // parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_RECHDR  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_TRAIL   = 3'd3;
  localparam logic [2:0] PH_DRAIN   = 3'd4;

  // summary status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_MAGIC      = 4'd2;
  localparam logic [3:0] ST_VERSION    = 4'd3;
  localparam logic [3:0] ST_ZERO_PSIZE = 4'd4;
  localparam logic [3:0] ST_COUNT      = 4'd5;
  localparam logic [3:0] ST_TRUNC      = 4'd6;
  localparam logic [3:0] ST_LENGTH     = 4'd7;
  localparam logic [3:0] ST_RANGE      = 4'd8;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        short_hdr;
    logic [63:0] total;
  } ckv_entry_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h52;
      3'd2:    b = 8'h4B;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h30;
      3'd6:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/checkpoint_container_validator.sv @@
// ----------------------------------------------------------------------------
// checkpoint_container_validator
// checks a checkpoint container byte stream and reports one summary per
// container
// ----------------------------------------------------------------------------
// bytes come in on the s_ stream, one per transfer, s_tlast on the final byte
// of a container. the m_ stream carries one summary per container: status
// code, header fields, highest record page and the byte count.
// cfg_ writes the expected version word; it is always ready. the user must write it
// only while no container is in flight; the block does not enforce this. reset value of the version is 1.
// throughput: one byte per cycle, bar a last byte held while a summary waits on m_tready,
// set by the back-end parser that consumes one queued byte each cycle.
// with the queue empty the summary reaches m_tvalid through the queue write
// and then the parser's output register.
// a 4-entry queue separates front and back; while a summary waits on
// m_tready the parser holds the next container's last byte, other bytes
// still drain, and s_tready drops once the queue is full.
// reset clears the queue, counters, parser state and the output valid flag.
// after each summary the parser and byte count restart for the next
// container.
// ----------------------------------------------------------------------------
module checkpoint_container_validator
  import ckv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // data_byte
  input  logic                s_tlast,   // end_of_buffer
  output logic                m_tvalid,
  input  logic                m_tready,
  // status, version word, page bytes, database pages, record count,
  // highest page, total bytes, zero pad
  output logic [OUT_BITS-1:0] m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  logic       push;
  logic       q_ready;
  logic       q_valid;
  logic       pop;
  ckv_entry_t push_entry;
  ckv_entry_t q_entry;

  ckv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .q_ready    (q_ready),
    .push_entry (push_entry)
  );

  ckv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .q_valid    (q_valid),
    .pop        (pop),
    .q_entry    (q_entry)
  );

  ckv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_summary_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pop && q_entry.last))
    else $error("summary without a last byte");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= ST_RANGE)
    else $error("status code out of range");

endmodule

@@ rtl/ckv_front.sv @@
// ----------------------------------------------------------------------------
// ckv_front
// accepts container bytes, counts them and tags each with its running total
// ----------------------------------------------------------------------------
module ckv_front
  import ckv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,   // end_of_buffer
  output logic       push,
  input  logic       q_ready,
  output ckv_entry_t push_entry
);

  logic [63:0] total;
  logic [63:0] total_next;

  assign s_tready   = q_ready;
  assign push       = s_tvalid && q_ready;
  assign total_next = (total == {64{1'b1}}) ? total : total + 64'd1;

  always_comb begin
    push_entry.data      = s_tdata;
    push_entry.last      = s_tlast;
    push_entry.total     = total_next;
    push_entry.short_hdr = total_next < 64'(HEADER_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (push) begin
      total <= s_tlast ? 64'd0 : total_next;
    end
  end

endmodule

@@ rtl/ckv_queue.sv @@
// ----------------------------------------------------------------------------
// ckv_queue
// short queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module ckv_queue
  import ckv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ckv_entry_t push_entry,
  output logic       q_ready,
  output logic       q_valid,
  input  logic       pop,
  output ckv_entry_t q_entry
);

  ckv_entry_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]       wr_ptr;
  logic [QUEUE_AW-1:0]       rd_ptr;
  logic [QUEUE_AW:0]         count;

  assign q_ready = count != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/ckv_parse.sv @@
// ----------------------------------------------------------------------------
// ckv_parse
// walks header and records one byte a cycle, a last byte only when no summary waits, and registers the summary
// ----------------------------------------------------------------------------
module ckv_parse
  import ckv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  input  logic                q_valid,
  input  ckv_entry_t          q_entry,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata
);

  logic [31:0] expected_version;
  logic [2:0]  phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic [63:0] shift, shift_next;
  logic [31:0] hdr_version, hdr_version_next;
  logic [31:0] hdr_psize, hdr_psize_next;
  logic [63:0] hdr_db_pages, hdr_db_pages_next;
  logic [31:0] hdr_count, hdr_count_next;
  logic [31:0] records_done, records_done_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] max_page, max_page_next;
  logic [3:0]  err, err_next;
  logic [3:0]  set_code;
  logic [3:0]  status;
  logic [31:0] word;
  logic [31:0] done_inc;
  logic [31:0] left_dec;

  assign cfg_ready = 1'b1;
  assign pop       = q_valid && (!q_entry.last || !m_tvalid || m_tready);

  assign shift_next = {q_entry.data, shift[63:8]};
  assign word       = shift_next[63:32];
  assign done_inc   = records_done + 32'd1;
  assign left_dec   = payload_left - 32'd1;

  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    hdr_version_next   = hdr_version;
    hdr_psize_next     = hdr_psize;
    hdr_db_pages_next  = hdr_db_pages;
    hdr_count_next     = hdr_count;
    records_done_next  = records_done;
    payload_left_next  = payload_left;
    max_page_next      = max_page;
    set_code           = ST_OK;
    unique case (phase)
      PH_HEADER: begin
        if (pos < 5'd8) begin
          if (q_entry.data != magic_byte(pos[2:0])) begin
            set_code = ST_MAGIC;
          end
        end
        case (pos)
          5'd11: begin
            hdr_version_next = word;
            if (word != expected_version) begin
              set_code = ST_VERSION;
            end
          end
          5'd15: begin
            hdr_psize_next = word;
            if (word == '0) begin
              set_code = ST_ZERO_PSIZE;
            end
          end
          5'd23: hdr_db_pages_next = shift_next;
          5'd27: begin
            hdr_count_next = word;
            if (word == '0) begin
              set_code = ST_COUNT;
            end
          end
          default: ;
        endcase
        if (pos == 5'(HEADER_BYTES - 1)) begin
          pos_next          = '0;
          records_done_next = '0;
          phase_next        = (err != ST_OK) ? PH_DRAIN : PH_RECHDR;
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      PH_RECHDR: begin
        if (pos == 5'd3 && word > max_page) begin
          max_page_next = word;
        end
        if (pos >= 5'd11) begin
          payload_left_next = word;
          pos_next          = '0;
          if (word == '0) begin
            records_done_next = done_inc;
            phase_next        = (done_inc == hdr_count) ? PH_TRAIL : PH_RECHDR;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = left_dec;
        if (left_dec == '0) begin
          records_done_next = done_inc;
          pos_next          = '0;
          phase_next        = (done_inc == hdr_count) ? PH_TRAIL : PH_RECHDR;
        end
      end
      PH_TRAIL: begin
        set_code   = ST_LENGTH;
        phase_next = PH_DRAIN;
      end
      default: ;
    endcase
    err_next = (err == ST_OK) ? set_code : err;

    if (q_entry.short_hdr) begin
      status = ST_SHORT;
    end else if (err_next != ST_OK) begin
      status = err_next;
    end else if (phase_next != PH_TRAIL) begin
      status = ST_TRUNC;
    end else if (max_page_next == '0 || {32'd0, max_page_next} > hdr_db_pages_next) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 32'd1;
    end else if (cfg_valid) begin
      expected_version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && q_entry.last)) begin
      phase         <= PH_HEADER;
      pos           <= '0;
      shift         <= '0;
      hdr_version   <= '0;
      hdr_psize     <= '0;
      hdr_db_pages  <= '0;
      hdr_count     <= '0;
      records_done  <= '0;
      payload_left  <= '0;
      max_page      <= '0;
      err           <= ST_OK;
    end else if (pop) begin
      phase         <= phase_next;
      pos           <= pos_next;
      shift         <= shift_next;
      hdr_version   <= hdr_version_next;
      hdr_psize     <= hdr_psize_next;
      hdr_db_pages  <= hdr_db_pages_next;
      hdr_count     <= hdr_count_next;
      records_done  <= records_done_next;
      payload_left  <= payload_left_next;
      max_page      <= max_page_next;
      err           <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && q_entry.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      m_tdata <= {4'd0, q_entry.total, max_page_next, hdr_count_next, hdr_db_pages_next,
                  hdr_psize_next, hdr_version_next, status};
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives checkpoint containers into the validator byte by byte and checks
// every summary against a behavioral parser kept in step with the stream;
// directed containers for each status code, then random containers with
// corruption, truncation, trailing bytes and noise under several versions
// ----------------------------------------------------------------------------
module testbench;
  import ckv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SIGNATURE = 64'h0031_3050_434B_5241;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] version;
    logic [31:0] psize;
    logic [63:0] db_pages;
    logic [31:0] count;
    logic [31:0] top_page;
    logic [63:0] total;
  } summary_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // data_byte
  logic                s_tlast = 1'b0; // end_of_buffer
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // status, version word, page bytes, database pages, record count,
  // highest page, total bytes, zero pad
  logic [OUT_BITS-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [31:0]         cfg_data = '0;

  checkpoint_container_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  byte_item_t byte_q[$];
  summary_t   summary_q[$];
  logic [7:0] frame[$];
  int         bytes_sent = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;

  // parser copy
  logic [2:0]  ps_phase;
  int          ps_pos;
  logic [63:0] ps_shift;
  logic [31:0] ps_version;
  logic [31:0] ps_psize;
  logic [63:0] ps_dbpages;
  logic [31:0] ps_count;
  logic [31:0] ps_done;
  logic [31:0] ps_page;
  logic [31:0] ps_left;
  logic [31:0] ps_maxpage;
  logic [63:0] ps_total;
  logic [3:0]  ps_err;
  logic [31:0] want_version = 32'd1;

  task automatic clear_parse();
    ps_phase   = PH_HEADER;
    ps_pos     = 0;
    ps_shift   = '0;
    ps_version = '0;
    ps_psize   = '0;
    ps_dbpages = '0;
    ps_count   = '0;
    ps_done    = '0;
    ps_page    = '0;
    ps_left    = '0;
    ps_maxpage = '0;
    ps_total   = '0;
    ps_err     = ST_OK;
  endtask

  task automatic flag_error(input logic [3:0] code);
    if (ps_err == ST_OK) ps_err = code;
  endtask

  task automatic collect(input logic [7:0] b, input int k);
    if (k == 0) ps_shift = '0;
    ps_shift = ps_shift | (64'(b) << (8 * (k % 8)));
  endtask

  task automatic close_record();
    ps_done = ps_done + 1;
    ps_phase = (ps_done == ps_count) ? PH_TRAIL : PH_RECHDR;
    ps_pos = 0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    summary_t s;
    int p;
    p = ps_pos;
    if (ps_total != '1) ps_total = ps_total + 1;
    case (ps_phase)
      PH_HEADER: begin
        if (p < 8) begin
          if (b != SIGNATURE[8*p +: 8]) flag_error(ST_MAGIC);
        end else if (p < 12) begin
          collect(b, p - 8);
          if (p == 11) begin
            ps_version = ps_shift[31:0];
            if (ps_version != want_version) flag_error(ST_VERSION);
          end
        end else if (p < 16) begin
          collect(b, p - 12);
          if (p == 15) begin
            ps_psize = ps_shift[31:0];
            if (ps_psize == 0) flag_error(ST_ZERO_PSIZE);
          end
        end else if (p < 24) begin
          collect(b, p - 16);
          if (p == 23) ps_dbpages = ps_shift;
        end else if (p < 28) begin
          collect(b, p - 24);
          if (p == 27) begin
            ps_count = ps_shift[31:0];
            if (ps_count == 0) flag_error(ST_COUNT);
          end
        end
        if (p + 1 >= HEADER_BYTES) begin
          ps_pos = 0;
          ps_done = 0;
          ps_phase = (ps_err != ST_OK) ? PH_DRAIN : PH_RECHDR;
        end else begin
          ps_pos = p + 1;
        end
      end
      PH_RECHDR: begin
        collect(b, p % 4);
        if (p == 3) begin
          ps_page = ps_shift[31:0];
          if (ps_page > ps_maxpage) ps_maxpage = ps_page;
        end
        if (p >= 11) begin
          ps_left = ps_shift[31:0];
          if (ps_left == 0) begin
            close_record();
          end else begin
            ps_phase = PH_PAYLOAD;
            ps_pos = 0;
          end
        end else begin
          ps_pos = p + 1;
        end
      end
      PH_PAYLOAD: begin
        ps_left = ps_left - 1;
        if (ps_left == 0) close_record();
      end
      PH_TRAIL: begin
        flag_error(ST_LENGTH);
        ps_phase = PH_DRAIN;
      end
      default: ;
    endcase
    if (last) begin
      if (ps_total < HEADER_BYTES) s.status = ST_SHORT;
      else if (ps_err != ST_OK) s.status = ps_err;
      else if (ps_phase != PH_TRAIL) s.status = ST_TRUNC;
      else if (ps_maxpage == 0 || {32'b0, ps_maxpage} > ps_dbpages) s.status = ST_RANGE;
      else s.status = ST_OK;
      s.version   = ps_version;
      s.psize     = ps_psize;
      s.db_pages  = ps_dbpages;
      s.count     = ps_count;
      s.top_page  = ps_maxpage;
      s.total     = ps_total;
      summary_q.push_back(s);
      clear_parse();
    end
  endtask

  // sender: bursts with random gaps
  byte_item_t next_item;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_item = byte_q.pop_front();
          s_tdata  <= next_item.data;
          s_tlast  <= next_item.last;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall mode, re-drawn when its random span runs out
  int   rx_mode = 0;
  int   rx_span = 0;
  int   rx_tick = 0;
  logic rx_ready;

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(8, 64);
    end else begin
      rx_span--;
    end
    rx_tick++;
    case (rx_mode)
      0: rx_ready = 1'b1;
      1: rx_ready = 1'($urandom_range(0, 1));
      2: rx_ready = ($urandom_range(0, 3) == 0);
      default: rx_ready = (rx_tick % 4 != 0);
    endcase
    m_tready <= rx_ready;
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  summary_t want_sum;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (summary_q.size() == 0) begin
        if (mismatches < 10) $display("summary transfer with none expected: %h", m_tdata);
        mismatches++;
      end else begin
        want_sum = summary_q.pop_front();
        compare_field("status", 64'(want_sum.status), 64'(m_tdata[3:0]));
        compare_field("version", 64'(want_sum.version), 64'(m_tdata[35:4]));
        compare_field("page_bytes", 64'(want_sum.psize), 64'(m_tdata[67:36]));
        compare_field("database_pages", want_sum.db_pages, m_tdata[131:68]);
        compare_field("record_count", 64'(want_sum.count), 64'(m_tdata[163:132]));
        compare_field("highest_page", 64'(want_sum.top_page), 64'(m_tdata[195:164]));
        compare_field("total_bytes", want_sum.total, m_tdata[259:196]);
      end
    end
  end

  // container building
  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) frame.push_back(v[8*i +: 8]);
  endtask

  task automatic put_header(input logic [31:0] ver, input logic [31:0] psize,
                            input logic [63:0] dbp, input logic [31:0] cnt);
    put_le(SIGNATURE, 8);
    put_le(64'(ver), 4);
    put_le(64'(psize), 4);
    put_le(dbp, 8);
    put_le(64'(cnt), 4);
    put_le(64'($urandom), 4);
  endtask

  task automatic put_record(input logic [31:0] page, input logic [31:0] size,
                            input logic with_payload);
    put_le(64'(page), 4);
    put_le(64'($urandom), 4);
    put_le(64'(size), 4);
    if (with_payload) repeat (size) frame.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic ship();
    byte_item_t it;
    for (int i = 0; i < frame.size(); i++) begin
      it.data = frame[i];
      it.last = (i == frame.size() - 1);
      byte_q.push_back(it);
    end
    bytes_sent += frame.size();
    frame.delete();
  endtask

  task automatic rand_container(input logic [31:0] ver);
    int kind;
    int cnt;
    int n;
    int idx;
    logic [31:0] vword;
    logic [31:0] psize;
    logic [31:0] page;
    logic [31:0] size;
    logic [63:0] dbp;
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      n = $urandom_range(1, 40);
      repeat (n) frame.push_back(8'($urandom_range(0, 255)));
      ship();
      return;
    end
    vword = (kind >= 79 && kind <= 82) ? ver ^ (32'd1 << $urandom_range(0, 31)) : ver;
    psize = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 65536);
    if (psize == 0) psize = 1;
    if (kind >= 83 && kind <= 85) psize = 0;
    cnt = (kind >= 86 && kind <= 88) ? 0 : $urandom_range(1, 3);
    dbp = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1, 40));
    if (kind >= 89 && kind <= 91) dbp = 64'($urandom_range(1, 40));
    put_header(vword, psize, dbp, cnt);
    for (int r = 0; r < cnt; r++) begin
      if (kind >= 89 && kind <= 91) page = $urandom_range(0, 1) ? 0 : dbp[31:0] + 1;
      else if (dbp > 40) page = $urandom;
      else page = $urandom_range(1, dbp[31:0]);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
      put_record(page, size, 1'b1);
    end
    if (kind >= 60 && kind <= 66) begin
      n = $urandom_range(1, frame.size() - 1);
      while (frame.size() > n) void'(frame.pop_back());
    end else if (kind >= 67 && kind <= 72) begin
      repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 73 && kind <= 78) begin
      idx = $urandom_range(0, frame.size() - 1);
      frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
    end
    ship();
  endtask

  task automatic run_random(input logic [31:0] ver);
    int start;
    int made;
    start = bytes_sent;
    made = 0;
    while (bytes_sent - start < 180 || made < 3) begin
      rand_container(ver);
      made++;
    end
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_sent || summary_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_version(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    want_version = v;
  endtask

  initial begin
    clear_parse();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // clean containers
    put_header(32'd1, 32'd4096, 64'd1, 32'd1);
    put_record(32'd1, 32'd0, 1'b1);
    ship();
    put_header(32'd1, 32'd512, 64'd10, 32'd2);
    put_record(32'd3, 32'd5, 1'b1);
    put_record(32'd7, 32'd2, 1'b1);
    ship();
    // short streams
    frame.push_back(8'h41);
    ship();
    put_header(32'd1, 32'd512, 64'd10, 32'd1);
    void'(frame.pop_back());
    ship();
    // header alone with records owed
    put_header(32'd1, 32'd512, 64'd10, 32'd1);
    ship();
    // header field errors
    put_header(32'd1, 32'd512, 64'd10, 32'd1);
    frame[2] = frame[2] ^ 8'h01;
    put_record(32'd1, 32'd0, 1'b1);
    ship();
    put_header(32'd2, 32'd512, 64'd10, 32'd1);
    put_record(32'd1, 32'd0, 1'b1);
    ship();
    put_header(32'd1, 32'd0, 64'd10, 32'd1);
    put_record(32'd1, 32'd0, 1'b1);
    ship();
    put_header(32'd1, 32'd512, 64'd10, 32'd0);
    ship();
    // first failing field decides
    put_header(32'd7, 32'd0, 64'd10, 32'd0);
    frame[7] = 8'hFF;
    ship();
    // trailing byte
    put_header(32'd1, 32'd512, 64'd10, 32'd1);
    put_record(32'd4, 32'd1, 1'b1);
    frame.push_back(8'hFF);
    ship();
    // page range
    put_header(32'd1, 32'd512, 64'd10, 32'd1);
    put_record(32'd0, 32'd3, 1'b1);
    ship();
    put_header(32'd1, 32'd512, 64'd10, 32'd2);
    put_record(32'd5, 32'd0, 1'b1);
    put_record(32'd11, 32'd1, 1'b1);
    ship();
    // field extremes
    put_header(32'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    put_record(32'hFFFF_FFFF, 32'd0, 1'b1);
    ship();
    put_header(32'd1, 32'd1, 64'd5, 32'd1);
    put_record(32'd2, 32'hFFFF_FFFF, 1'b0);
    repeat (3) frame.push_back(8'($urandom_range(0, 255)));
    ship();
    // cut inside a record header
    put_header(32'd1, 32'd64, 64'd4, 32'd2);
    put_record(32'd2, 32'd3, 1'b1);
    put_le(64'd3, 4);
    ship();
    run_random(32'd1);

    wait_idle();
    write_version(32'd0);
    run_random(32'd0);
    wait_idle();
    write_version(32'hFFFF_FFFF);
    run_random(32'hFFFF_FFFF);
    wait_idle();
    write_version($urandom);
    run_random(want_version);
    wait_idle();
    write_version(32'd1);
    run_random(32'd1);
    wait_idle();

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ckv_pkg.sv
rtl/ckv_front.sv
rtl/ckv_queue.sv
rtl/ckv_parse.sv
rtl/checkpoint_container_validator.sv
tb/testbench.sv
